// ===== rtl/bra_pkg.sv =====
// ----------------------------------------------------------------------------
// bra_pkg
// Shared constants, codes and lane interface types of the deadlock-avoidance
// allocator.
// ----------------------------------------------------------------------------
package bra_pkg;

    localparam int NUM_CUSTOMERS = 5;
    localparam int NUM_TYPES     = 4;
    localparam int COUNT_W       = 12;

    // Fixed field widths of the streams
    localparam int CUST_W     = 3;
    localparam int STATUS_W   = 3;
    localparam int OUT_TYPES  = 4;
    localparam int S_TDATA_W  = ((CUST_W + OUT_TYPES * COUNT_W) + 7) / 8 * 8;
    localparam int M_TDATA_W  = ((STATUS_W + OUT_TYPES * COUNT_W) + 7) / 8 * 8;

    // Derived widths
    localparam int IDX_W      = (NUM_CUSTOMERS > 1) ? $clog2(NUM_CUSTOMERS) : 1;
    localparam int SUM_W      = COUNT_W + $clog2(NUM_CUSTOMERS);
    localparam int SW         = SUM_W + 1;
    localparam int REG_W      = NUM_TYPES * COUNT_W;
    localparam int CFG_ADDR_W = $clog2(NUM_CUSTOMERS + 1);

    localparam logic [CFG_ADDR_W-1:0] CFG_INIT_AVAIL = '0;

    localparam logic MODE_REQUEST = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED         = 3'd0,
        ST_EXCEEDS_NEED    = 3'd1,
        ST_EXCEEDS_AVAIL   = 3'd2,
        ST_UNSAFE          = 3'd3,
        ST_RELEASED        = 3'd4,
        ST_RELEASE_EXCEEDS = 3'd5,
        ST_BAD_CUSTOMER    = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        AOP_NONE,
        AOP_GRANT,
        AOP_RETURN
    } alloc_op_t;

    typedef enum logic [1:0] {
        WOP_HOLD,
        WOP_LOAD,
        WOP_ACCUM
    } work_op_t;

    typedef struct packed {
        logic [IDX_W-1:0] addr;
        alloc_op_t        alloc_op;
        work_op_t         work_op;
    } lane_ctrl_t;

    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   idx;
        logic [COUNT_W-1:0] val;
    } lane_cfg_t;

    typedef struct packed {
        logic               fail_need;
        logic               fail_avail;
        logic               fail_rel;
        logic               fits;
        logic [COUNT_W-1:0] avail_out;
    } lane_res_t;

    typedef struct packed {
        status_t status;
        logic    fits_all;
    } merge_t;

endpackage

// ===== rtl/bra_lane.sv =====
// ----------------------------------------------------------------------------
// bra_lane
// One resource type: its column of the allocation matrix, the claim slices,
// the running column sum and the safety-walk work count.
// ----------------------------------------------------------------------------
module bra_lane (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  bra_pkg::lane_cfg_t          cfg,
    input  logic [bra_pkg::COUNT_W-1:0] init_val,
    input  bra_pkg::lane_ctrl_t         ctrl,
    input  logic [bra_pkg::COUNT_W-1:0] amt,
    output bra_pkg::lane_res_t          res
);

    logic [bra_pkg::COUNT_W-1:0] max_reg   [bra_pkg::NUM_CUSTOMERS];
    logic [bra_pkg::COUNT_W-1:0] alloc_reg [bra_pkg::NUM_CUSTOMERS];
    logic [bra_pkg::SUM_W-1:0]   colsum_reg;
    logic signed [bra_pkg::SW-1:0] work_reg;

    logic                          addr_ok;
    logic [bra_pkg::COUNT_W-1:0]   max_sel;
    logic [bra_pkg::COUNT_W-1:0]   alloc_sel;
    logic signed [bra_pkg::SW-1:0] need;
    logic signed [bra_pkg::SW-1:0] avail;
    logic signed [bra_pkg::SW-1:0] amt_s;

    assign addr_ok = {1'b0, ctrl.addr} < (bra_pkg::IDX_W + 1)'(bra_pkg::NUM_CUSTOMERS);

    always_comb begin
        max_sel   = addr_ok ? max_reg[ctrl.addr]   : '0;
        alloc_sel = addr_ok ? alloc_reg[ctrl.addr] : '0;
        amt_s     = $signed(bra_pkg::SW'(amt));
        need      = $signed(bra_pkg::SW'(max_sel)) - $signed(bra_pkg::SW'(alloc_sel));
        avail     = $signed(bra_pkg::SW'(init_val)) - $signed(bra_pkg::SW'(colsum_reg));

        res.fail_need  = amt_s > need;
        res.fail_avail = amt_s > avail;
        res.fail_rel   = amt > alloc_sel;
        res.fits       = need <= work_reg;
        // report a negative count as zero
        res.avail_out  = avail[bra_pkg::SW-1] ? '0 : avail[bra_pkg::COUNT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < bra_pkg::NUM_CUSTOMERS; c++) begin
                max_reg[c]   <= '0;
                alloc_reg[c] <= '0;
            end
            colsum_reg <= '0;
            work_reg   <= '0;
        end else begin
            if (cfg.we) begin
                max_reg[cfg.idx] <= cfg.val;
            end
            unique case (ctrl.alloc_op)
                bra_pkg::AOP_GRANT: begin
                    alloc_reg[ctrl.addr] <= alloc_sel + amt;
                    colsum_reg           <= colsum_reg + bra_pkg::SUM_W'(amt);
                end
                bra_pkg::AOP_RETURN: begin
                    alloc_reg[ctrl.addr] <= alloc_sel - amt;
                    colsum_reg           <= colsum_reg - bra_pkg::SUM_W'(amt);
                end
                default: ;
            endcase
            unique case (ctrl.work_op)
                bra_pkg::WOP_LOAD:  work_reg <= avail - amt_s;
                bra_pkg::WOP_ACCUM: work_reg <= work_reg + $signed(bra_pkg::SW'(alloc_sel));
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/bra_merge.sv =====
// ----------------------------------------------------------------------------
// bra_merge
// Combines the per-type lane flags into one check status and the
// all-types fit decision of the safety walk.
// ----------------------------------------------------------------------------
module bra_merge (
    input  bra_pkg::lane_res_t res [bra_pkg::NUM_TYPES],
    input  logic               mode,
    input  logic               cust_ok,
    output bra_pkg::merge_t    merged
);

    bra_pkg::status_t req_status;
    logic             rel_fail;
    logic             fits_all;

    always_comb begin
        req_status = bra_pkg::ST_GRANTED;
        rel_fail   = 1'b0;
        fits_all   = 1'b1;
        // walk down so the lowest failing type wins; need is checked before available
        for (int t = bra_pkg::NUM_TYPES - 1; t >= 0; t--) begin
            if (res[t].fail_need) begin
                req_status = bra_pkg::ST_EXCEEDS_NEED;
            end else if (res[t].fail_avail) begin
                req_status = bra_pkg::ST_EXCEEDS_AVAIL;
            end
            rel_fail = rel_fail | res[t].fail_rel;
            fits_all = fits_all & res[t].fits;
        end

        merged.fits_all = fits_all;
        priority if (!cust_ok) begin
            merged.status = bra_pkg::ST_BAD_CUSTOMER;
        end else if (mode == bra_pkg::MODE_RELEASE) begin
            merged.status = rel_fail ? bra_pkg::ST_RELEASE_EXCEEDS : bra_pkg::ST_RELEASED;
        end else begin
            merged.status = req_status;
        end
    end

endmodule

// ===== rtl/bankers_resource_allocator_core.sv =====
// ----------------------------------------------------------------------------
// bankers_resource_allocator_core
// Banker's deadlock-avoidance allocator, five customers by four resource types.
// ----------------------------------------------------------------------------
// Each transaction is a request or a release for one customer and returns one
// status plus the four available counts. Four lanes, one per resource type,
// check an item; a granted request then runs the safety walk, which visits one
// customer per cycle with all lanes comparing in parallel, for at most five
// passes of five customers. A rejected request, a release or a bad customer
// goes through accept, check and result; a passing request through accept,
// check, walk, a rollback when unsafe, and result. One item is processed at a
// time; the next is taken while the last result waits on the output register.
// Configuration is written through cfg_we/cfg_addr/cfg_wdata while the block
// is idle: address 0 sets the initial totals, addresses 1..5 the maximum
// claims of customers 0..4.
// ----------------------------------------------------------------------------
module bankers_resource_allocator_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [bra_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [bra_pkg::REG_W-1:0]         cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // customer, amount_r0, amount_r1, amount_r2, amount_r3, zero pad
    input  logic [bra_pkg::S_TDATA_W-1:0]     s_tdata,
    // mode
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // status, avail_r0, avail_r1, avail_r2, avail_r3, zero pad
    output logic [bra_pkg::M_TDATA_W-1:0]     m_tdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_WALK,
        S_UNDO,
        S_FIN
    } state_t;

    state_t                                state_reg, state_next;
    logic                                  mode_reg, mode_next;
    logic [bra_pkg::CUST_W-1:0]            cust_reg, cust_next;
    logic [bra_pkg::COUNT_W-1:0]           amt_reg  [bra_pkg::NUM_TYPES];
    logic [bra_pkg::COUNT_W-1:0]           amt_next [bra_pkg::NUM_TYPES];
    bra_pkg::status_t                      status_reg, status_next;
    logic [bra_pkg::IDX_W-1:0]             walk_c_reg, walk_c_next;
    logic [bra_pkg::NUM_CUSTOMERS-1:0]     done_reg, done_next;
    logic                                  progress_reg, progress_next;
    logic                                  m_tvalid_reg, m_tvalid_next;
    logic [bra_pkg::M_TDATA_W-1:0]         m_tdata_reg, m_tdata_next;
    logic [bra_pkg::REG_W-1:0]             init_reg;

    logic                                  cust_ok;
    logic [bra_pkg::IDX_W-1:0]             cust_idx;
    bra_pkg::lane_ctrl_t                   lane_ctrl;
    bra_pkg::lane_cfg_t                    lane_cfg [bra_pkg::NUM_TYPES];
    bra_pkg::lane_res_t                    lane_res [bra_pkg::NUM_TYPES];
    bra_pkg::merge_t                       merged;
    logic                                  max_we;
    logic [bra_pkg::CFG_ADDR_W-1:0]        max_idx;

    assign cust_ok  = cust_reg < bra_pkg::CUST_W'(bra_pkg::NUM_CUSTOMERS);
    assign cust_idx = cust_reg[bra_pkg::IDX_W-1:0];
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // claim registers live in the lanes; split each write into per-type slices
    assign max_we  = cfg_we && (cfg_addr != bra_pkg::CFG_INIT_AVAIL)
                     && (cfg_addr <= bra_pkg::CFG_ADDR_W'(bra_pkg::NUM_CUSTOMERS));
    assign max_idx = cfg_addr - bra_pkg::CFG_ADDR_W'(1);

    for (genvar t = 0; t < bra_pkg::NUM_TYPES; t++) begin : g_lane
        assign lane_cfg[t].we  = max_we;
        assign lane_cfg[t].idx = max_idx[bra_pkg::IDX_W-1:0];
        assign lane_cfg[t].val = cfg_wdata[t*bra_pkg::COUNT_W +: bra_pkg::COUNT_W];

        bra_lane u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cfg      (lane_cfg[t]),
            .init_val (init_reg[t*bra_pkg::COUNT_W +: bra_pkg::COUNT_W]),
            .ctrl     (lane_ctrl),
            .amt      (amt_reg[t]),
            .res      (lane_res[t])
        );
    end

    bra_merge u_merge (
        .res     (lane_res),
        .mode    (mode_reg),
        .cust_ok (cust_ok),
        .merged  (merged)
    );

    always_comb begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        cust_next     = cust_reg;
        amt_next      = amt_reg;
        status_next   = status_reg;
        walk_c_next   = walk_c_reg;
        done_next     = done_reg;
        progress_next = progress_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        lane_ctrl.addr     = cust_idx;
        lane_ctrl.alloc_op = bra_pkg::AOP_NONE;
        lane_ctrl.work_op  = bra_pkg::WOP_HOLD;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    mode_next = s_tuser;
                    cust_next = s_tdata[bra_pkg::CUST_W-1:0];
                    for (int t = 0; t < bra_pkg::NUM_TYPES; t++) begin
                        amt_next[t] = s_tdata[bra_pkg::CUST_W + t*bra_pkg::COUNT_W
                                              +: bra_pkg::COUNT_W];
                    end
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                status_next = merged.status;
                state_next  = S_FIN;
                if (cust_ok && mode_reg == bra_pkg::MODE_REQUEST
                    && merged.status == bra_pkg::ST_GRANTED) begin
                    // trial grant; the walk starts from the reduced available
                    lane_ctrl.alloc_op = bra_pkg::AOP_GRANT;
                    lane_ctrl.work_op  = bra_pkg::WOP_LOAD;
                    walk_c_next        = '0;
                    done_next          = '0;
                    progress_next      = 1'b0;
                    state_next         = S_WALK;
                end else if (cust_ok && mode_reg == bra_pkg::MODE_RELEASE
                             && merged.status == bra_pkg::ST_RELEASED) begin
                    lane_ctrl.alloc_op = bra_pkg::AOP_RETURN;
                end
            end
            S_WALK: begin
                lane_ctrl.addr = walk_c_reg;
                if (!done_reg[walk_c_reg] && merged.fits_all) begin
                    lane_ctrl.work_op      = bra_pkg::WOP_ACCUM;
                    done_next[walk_c_reg]  = 1'b1;
                    progress_next          = 1'b1;
                end
                // leave as soon as every customer has finished
                priority if (&done_next) begin
                    status_next = bra_pkg::ST_GRANTED;
                    state_next  = S_FIN;
                end else if (walk_c_reg == bra_pkg::IDX_W'(bra_pkg::NUM_CUSTOMERS - 1)) begin
                    if (!progress_next) begin
                        state_next  = S_UNDO;
                    end else begin
                        walk_c_next   = '0;
                        progress_next = 1'b0;
                    end
                end else begin
                    walk_c_next = walk_c_reg + bra_pkg::IDX_W'(1);
                end
            end
            S_UNDO: begin
                // drop the trial grant
                lane_ctrl.alloc_op = bra_pkg::AOP_RETURN;
                status_next        = bra_pkg::ST_UNSAFE;
                state_next         = S_FIN;
            end
            S_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tdata_next[bra_pkg::STATUS_W-1:0] = status_reg;
                    for (int t = 0; t < bra_pkg::NUM_TYPES; t++) begin
                        m_tdata_next[bra_pkg::STATUS_W + t*bra_pkg::COUNT_W
                                     +: bra_pkg::COUNT_W] = lane_res[t].avail_out;
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            walk_c_reg   <= '0;
            done_reg     <= '0;
            progress_reg <= 1'b0;
            init_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            walk_c_reg   <= walk_c_next;
            done_reg     <= done_next;
            progress_reg <= progress_next;
            if (cfg_we && cfg_addr == bra_pkg::CFG_INIT_AVAIL) begin
                init_reg <= cfg_wdata;
            end
        end
        mode_reg    <= mode_next;
        cust_reg    <= cust_next;
        amt_reg     <= amt_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
    end

    // A result only appears out of the result state
    a_result_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == S_FIN))
        else $error("result raised outside result state");

    // A bad customer never touches the allocation
    a_bad_cust_no_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CHECK && !cust_ok) |-> lane_ctrl.alloc_op == bra_pkg::AOP_NONE)
        else $error("allocation updated for bad customer");

    // The walk leaves as soon as every customer has finished
    a_walk_not_all_done: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_WALK |-> !(&done_reg))
        else $error("walk continued with all customers finished");

    // The walk index stays on a real customer
    a_walk_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_WALK
        |-> {1'b0, walk_c_reg} < (bra_pkg::IDX_W + 1)'(bra_pkg::NUM_CUSTOMERS))
        else $error("walk index out of range");

endmodule

// ===== tb/bra_allocation_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_allocation_checker
// Follows the configuration port and both streams of the allocator, keeps its
// own allocation matrix and compares every result transaction field by field.
// ----------------------------------------------------------------------------
module bra_allocation_checker
    import bra_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [REG_W-1:0]      cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    output int                    mismatch_count,
    output int                    pending
);

    typedef struct packed {
        status_t          status;
        logic [REG_W-1:0] avail;
    } outcome_t;

    logic [REG_W-1:0] total_cfg;
    logic [REG_W-1:0] claim_cfg [NUM_CUSTOMERS];
    int               held [NUM_CUSTOMERS][NUM_TYPES];
    outcome_t         expected_q [$];

    function automatic int field_of(input logic [REG_W-1:0] packed_counts, input int t);
        return int'(packed_counts[t*COUNT_W +: COUNT_W]);
    endfunction

    // Signed: totals and claims may be lowered below what is already held
    function automatic int free_units(input int t);
        int a;
        a = field_of(total_cfg, t);
        for (int c = 0; c < NUM_CUSTOMERS; c++)
            a -= held[c][t];
        return a;
    endfunction

    function automatic int still_needed(input int c, input int t);
        return field_of(claim_cfg[c], t) - held[c][t];
    endfunction

    function automatic bit state_is_safe();
        int work [NUM_TYPES];
        bit done [NUM_CUSTOMERS];
        int finished;
        bit progress;
        bit fits;
        finished = 0;
        for (int t = 0; t < NUM_TYPES; t++)
            work[t] = free_units(t);
        for (int c = 0; c < NUM_CUSTOMERS; c++)
            done[c] = 1'b0;
        while (finished < NUM_CUSTOMERS) begin
            progress = 1'b0;
            for (int c = 0; c < NUM_CUSTOMERS; c++) begin
                if (!done[c]) begin
                    fits = 1'b1;
                    for (int t = 0; t < NUM_TYPES; t++)
                        if (still_needed(c, t) > work[t])
                            fits = 1'b0;
                    if (fits) begin
                        for (int t = 0; t < NUM_TYPES; t++)
                            work[t] += held[c][t];
                        done[c]  = 1'b1;
                        progress = 1'b1;
                        finished++;
                    end
                end
            end
            if (!progress)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Apply one transaction to the matrix and return the result it must produce
    function automatic outcome_t settle_item(input logic mode, input logic [CUST_W-1:0] cust,
                                             input logic [REG_W-1:0] amounts);
        outcome_t res;
        int       c;
        int       amt;
        int       left;
        res.status = ST_GRANTED;
        c = int'(cust);
        if (c >= NUM_CUSTOMERS) begin
            res.status = ST_BAD_CUSTOMER;
        end else if (mode == MODE_REQUEST) begin
            for (int t = 0; t < NUM_TYPES; t++) begin
                amt = field_of(amounts, t);
                if (amt > still_needed(c, t)) begin
                    res.status = ST_EXCEEDS_NEED;
                    break;
                end
                if (amt > free_units(t)) begin
                    res.status = ST_EXCEEDS_AVAIL;
                    break;
                end
            end
            if (res.status == ST_GRANTED) begin
                for (int t = 0; t < NUM_TYPES; t++)
                    held[c][t] += field_of(amounts, t);
                // roll back a trial grant that leaves no safe order
                if (!state_is_safe()) begin
                    for (int t = 0; t < NUM_TYPES; t++)
                        held[c][t] -= field_of(amounts, t);
                    res.status = ST_UNSAFE;
                end
            end
        end else begin
            res.status = ST_RELEASED;
            for (int t = 0; t < NUM_TYPES; t++) begin
                if (field_of(amounts, t) > held[c][t]) begin
                    res.status = ST_RELEASE_EXCEEDS;
                    break;
                end
            end
            if (res.status == ST_RELEASED)
                for (int t = 0; t < NUM_TYPES; t++)
                    held[c][t] -= field_of(amounts, t);
        end
        for (int t = 0; t < OUT_TYPES; t++) begin
            left = 0;
            if (t < NUM_TYPES)
                left = free_units(t);
            res.avail[t*COUNT_W +: COUNT_W] = (left < 0) ? '0 : left[COUNT_W-1:0];
        end
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        outcome_t              exp_res;
        logic [STATUS_W-1:0]   got_status;
        logic [REG_W-1:0]      got_avail;
        if (!aresetn) begin
            total_cfg = '0;
            for (int c = 0; c < NUM_CUSTOMERS; c++) begin
                claim_cfg[c] = '0;
                for (int t = 0; t < NUM_TYPES; t++)
                    held[c][t] = 0;
            end
            expected_q.delete();
            mismatch_count = 0;
            pending <= 0;
        end else begin
            if (cfg_we) begin
                if (cfg_addr == CFG_INIT_AVAIL)
                    total_cfg = cfg_wdata;
                else if (int'(cfg_addr) <= NUM_CUSTOMERS)
                    claim_cfg[int'(cfg_addr) - 1] = cfg_wdata;
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(settle_item(s_tuser, s_tdata[CUST_W-1:0],
                                                 s_tdata[CUST_W +: REG_W]));
            if (m_tvalid && m_tready) begin
                got_status = m_tdata[STATUS_W-1:0];
                got_avail  = m_tdata[STATUS_W +: REG_W];
                if (expected_q.size() == 0) begin
                    $display("%0t: result with nothing outstanding: expected none, got %h",
                             $time, m_tdata);
                    mismatch_count++;
                end else begin
                    exp_res = expected_q.pop_front();
                    if (got_status !== exp_res.status) begin
                        $display("%0t: status mismatch: expected %0d, got %0d",
                                 $time, exp_res.status, got_status);
                        mismatch_count++;
                    end
                    for (int t = 0; t < OUT_TYPES; t++) begin
                        if (got_avail[t*COUNT_W +: COUNT_W] !==
                            exp_res.avail[t*COUNT_W +: COUNT_W]) begin
                            $display("%0t: avail_r%0d mismatch: expected %0d, got %0d",
                                     $time, t, exp_res.avail[t*COUNT_W +: COUNT_W],
                                     got_avail[t*COUNT_W +: COUNT_W]);
                            mismatch_count++;
                        end
                    end
                end
            end
            pending <= expected_q.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the deadlock-avoidance allocator: a directed pass over the
// request, release and rejection paths, then random phases under changing
// totals and claims, with random idling on both streams and one long output
// hold-off. Checking is done by the allocation checker beside the block.
// ----------------------------------------------------------------------------
module tb;

    localparam int LAST_ADDR       = 2**bra_pkg::CFG_ADDR_W - 1;
    localparam int CUST_MAX        = 2**bra_pkg::CUST_W - 1;
    localparam int MAX_COUNT       = 2**bra_pkg::COUNT_W - 1;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int NUM_PHASES      = 7;

    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_we;
    logic [bra_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [bra_pkg::REG_W-1:0]      cfg_wdata;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [bra_pkg::S_TDATA_W-1:0]  s_tdata;
    logic                           s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [bra_pkg::M_TDATA_W-1:0]  m_tdata;

    int fail_count;
    int pending;
    int rx_count = 0;
    bit steady   = 1'b0;
    bit held_off = 1'b0;

    logic [bra_pkg::REG_W-1:0] total_set;
    logic [bra_pkg::REG_W-1:0] claim_set [bra_pkg::NUM_CUSTOMERS];
    int               phase_ceiling [NUM_PHASES] = '{12, 8, 20, 4095, 0, 6, 4095};

    bankers_resource_allocator_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    bra_allocation_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (fail_count),
        .pending        (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge aclk)
        if (m_tvalid && m_tready)
            rx_count <= rx_count + 1;

    // Result side: random stalls, one long hold-off so the input backs up
    initial begin
        m_tready = 1'b0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (!held_off && rx_count >= 700) begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
            end else begin
                m_tready <= steady || ($urandom_range(99) >= 19);
            end
        end
    end

    function automatic int field_at(input logic [bra_pkg::REG_W-1:0] packed_counts,
                                    input int t);
        return int'(packed_counts[t*bra_pkg::COUNT_W +: bra_pkg::COUNT_W]);
    endfunction

    function automatic logic [bra_pkg::REG_W-1:0] per_type(input int v0, input int v1,
                                                           input int v2, input int v3);
        logic [bra_pkg::REG_W-1:0] r;
        r = '0;
        r[0*bra_pkg::COUNT_W +: bra_pkg::COUNT_W] = v0[bra_pkg::COUNT_W-1:0];
        r[1*bra_pkg::COUNT_W +: bra_pkg::COUNT_W] = v1[bra_pkg::COUNT_W-1:0];
        r[2*bra_pkg::COUNT_W +: bra_pkg::COUNT_W] = v2[bra_pkg::COUNT_W-1:0];
        r[3*bra_pkg::COUNT_W +: bra_pkg::COUNT_W] = v3[bra_pkg::COUNT_W-1:0];
        return r;
    endfunction

    task automatic send_item(input logic mode, input int cust,
                             input logic [bra_pkg::REG_W-1:0] amounts);
        logic [bra_pkg::S_TDATA_W-1:0] word;
        int                            gap;
        if (!steady && $urandom_range(99) < 19) begin
            gap = ($urandom_range(9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        word = '0;
        word[bra_pkg::CUST_W-1:0]               = cust[bra_pkg::CUST_W-1:0];
        word[bra_pkg::CUST_W +: bra_pkg::REG_W] = amounts;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Drop valid and wait until every outstanding result has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (32) @(posedge aclk);
    endtask

    task automatic load_config();
        logic [bra_pkg::CFG_ADDR_W-1:0] addr;
        cfg_we    <= 1'b1;
        cfg_addr  <= bra_pkg::CFG_INIT_AVAIL;
        cfg_wdata <= total_set;
        @(posedge aclk);
        for (int c = 0; c < bra_pkg::NUM_CUSTOMERS; c++) begin
            addr = bra_pkg::CFG_ADDR_W'(c + 1);
            cfg_addr  <= addr;
            cfg_wdata <= claim_set[c];
            @(posedge aclk);
        end
        // spare indexes must leave everything untouched
        addr = bra_pkg::CFG_ADDR_W'($urandom_range(bra_pkg::NUM_CUSTOMERS + 1, LAST_ADDR));
        cfg_addr  <= addr;
        cfg_wdata <= bra_pkg::REG_W'({$urandom, $urandom});
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_config(input int ceiling);
        int tot;
        total_set = '0;
        for (int t = 0; t < bra_pkg::NUM_TYPES; t++) begin
            tot = int'($urandom_range(ceiling / 2, ceiling));
            total_set[t*bra_pkg::COUNT_W +: bra_pkg::COUNT_W] = tot[bra_pkg::COUNT_W-1:0];
            for (int c = 0; c < bra_pkg::NUM_CUSTOMERS; c++)
                claim_set[c][t*bra_pkg::COUNT_W +: bra_pkg::COUNT_W] =
                    bra_pkg::COUNT_W'($urandom_range(0, tot));
        end
    endtask

    task automatic random_item();
        int                        pick;
        int                        c;
        int                        div;
        int                        lim;
        logic                      mode;
        logic [bra_pkg::REG_W-1:0] amt;
        pick = int'($urandom_range(99));
        amt  = '0;
        if (pick < 8) begin
            mode = 1'($urandom_range(1));
            c    = int'($urandom_range(CUST_MAX));
            for (int t = 0; t < bra_pkg::NUM_TYPES; t++)
                amt[t*bra_pkg::COUNT_W +: bra_pkg::COUNT_W] = bra_pkg::COUNT_W'($urandom);
        end else if (pick < 12) begin
            mode = 1'($urandom_range(1));
            c    = int'($urandom_range(bra_pkg::NUM_CUSTOMERS, CUST_MAX));
            for (int t = 0; t < bra_pkg::NUM_TYPES; t++)
                amt[t*bra_pkg::COUNT_W +: bra_pkg::COUNT_W] =
                    bra_pkg::COUNT_W'($urandom_range(0, 15));
        end else if (pick < 62) begin
            mode = bra_pkg::MODE_REQUEST;
            c    = int'($urandom_range(bra_pkg::NUM_CUSTOMERS - 1));
            div  = int'($urandom_range(1, 3));
            for (int t = 0; t < bra_pkg::NUM_TYPES; t++)
                if ($urandom_range(3) != 0)
                    amt[t*bra_pkg::COUNT_W +: bra_pkg::COUNT_W] =
                        bra_pkg::COUNT_W'($urandom_range(0, field_at(claim_set[c], t) / div));
        end else begin
            mode = bra_pkg::MODE_RELEASE;
            c    = int'($urandom_range(bra_pkg::NUM_CUSTOMERS - 1));
            for (int t = 0; t < bra_pkg::NUM_TYPES; t++) begin
                lim = field_at(claim_set[c], t) / 3;
                if (lim < 1)
                    lim = 1;
                amt[t*bra_pkg::COUNT_W +: bra_pkg::COUNT_W] =
                    bra_pkg::COUNT_W'($urandom_range(0, lim));
            end
        end
        send_item(mode, c, amt);
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = bra_pkg::MODE_REQUEST;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset configuration: everything zero, zero amounts still walk
        send_item(bra_pkg::MODE_REQUEST, 0, per_type(0, 0, 0, 0));
        send_item(bra_pkg::MODE_REQUEST, 0, per_type(1, 0, 0, 0));
        send_item(bra_pkg::MODE_RELEASE, 4, per_type(0, 0, 0, 0));
        send_item(bra_pkg::MODE_RELEASE, 1, per_type(0, 0, 0, 1));
        send_item(bra_pkg::MODE_REQUEST, bra_pkg::NUM_CUSTOMERS, per_type(0, 0, 0, 0));
        send_item(bra_pkg::MODE_RELEASE, CUST_MAX,
                  per_type(MAX_COUNT, MAX_COUNT, MAX_COUNT, MAX_COUNT));
        send_item(bra_pkg::MODE_REQUEST, CUST_MAX - 1,
                  per_type(MAX_COUNT, MAX_COUNT, MAX_COUNT, MAX_COUNT));
        settle();

        // Full totals and claims: grant all, exhaust, unsafe, release
        total_set = per_type(MAX_COUNT, MAX_COUNT, MAX_COUNT, MAX_COUNT);
        for (int c = 0; c < bra_pkg::NUM_CUSTOMERS; c++)
            claim_set[c] = total_set;
        load_config();
        send_item(bra_pkg::MODE_REQUEST, 0,
                  per_type(MAX_COUNT, MAX_COUNT, MAX_COUNT, MAX_COUNT));
        send_item(bra_pkg::MODE_REQUEST, 1, per_type(0, 0, 0, 1));
        send_item(bra_pkg::MODE_RELEASE, 0,
                  per_type(MAX_COUNT, MAX_COUNT, MAX_COUNT, MAX_COUNT));
        send_item(bra_pkg::MODE_REQUEST, 0, per_type(3000, 3000, 3000, 3000));
        send_item(bra_pkg::MODE_REQUEST, 1, per_type(1000, 1000, 1000, 1000));
        send_item(bra_pkg::MODE_REQUEST, 1, per_type(2000, 0, 0, 0));
        send_item(bra_pkg::MODE_RELEASE, 0, per_type(3001, 0, 0, 0));
        settle();

        // Lower totals and a claim below what is held: negative available
        total_set    = per_type(1000, MAX_COUNT, 0, MAX_COUNT);
        claim_set[0] = per_type(100, 100, 100, 100);
        load_config();
        send_item(bra_pkg::MODE_REQUEST, 0, per_type(0, 0, 0, 0));
        send_item(bra_pkg::MODE_REQUEST, 2, per_type(1, 0, 0, 0));
        send_item(bra_pkg::MODE_RELEASE, 0, per_type(3000, 3000, 3000, 3000));
        send_item(bra_pkg::MODE_REQUEST, 2, per_type(1, 1, 0, 1));
        settle();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (phase_ceiling[ph] == 0) begin
                // shrink the previous setting while allocations are held
                for (int t = 0; t < bra_pkg::NUM_TYPES; t++) begin
                    total_set[t*bra_pkg::COUNT_W +: bra_pkg::COUNT_W] =
                        bra_pkg::COUNT_W'(field_at(total_set, t) / 2);
                    for (int c = 0; c < bra_pkg::NUM_CUSTOMERS; c++)
                        claim_set[c][t*bra_pkg::COUNT_W +: bra_pkg::COUNT_W] =
                            bra_pkg::COUNT_W'(field_at(claim_set[c], t) / 2);
                end
            end else begin
                random_config(phase_ceiling[ph]);
            end
            load_config();
            steady = (ph == 2);
            repeat (ITEMS_PER_PHASE) random_item();
            settle();
        end
        steady = 1'b0;

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
